/* hdl/ipv4tl_pkg.sv */
// Shared types and constants for the IPv4/TCP header locator.
package ipv4tl_pkg;

	// Parse phases
	localparam logic [2:0] PH_WAIT_IP = 3'd0;
	localparam logic [2:0] PH_CHAIN   = 3'd1;
	localparam logic [2:0] PH_AH_LEN  = 3'd2;
	localparam logic [2:0] PH_TCP     = 3'd3;
	localparam logic [2:0] PH_DONE    = 3'd4;

	// Verdict codes
	localparam logic [1:0] V_TCP_OK    = 2'd0;
	localparam logic [1:0] V_UNSUPP    = 2'd1;
	localparam logic [1:0] V_TRUNC     = 2'd2;
	localparam logic [1:0] V_TCP_BAD   = 2'd3;

	// Protocol numbers
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_AH  = 8'd51;

	// Header geometry
	localparam int unsigned IP_PROTO_BYTE = 9;
	localparam int unsigned TCP_DOFF_BYTE = 12;
	localparam int unsigned TCP_MIN_LEN   = 20;
	localparam int unsigned IHL_MIN       = 5;

	localparam int unsigned OFFSET_W = 16;

	typedef struct packed {
		logic       last;
		logic [7:0] data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          verdict;
		logic [OFFSET_W-1:0] offset;
	} result_t;

endpackage

/* hdl/ipv4tl_parser.sv */
// Per-packet parse state and combinational byte step logic.
module ipv4tl_parser
	import ipv4tl_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	output logic     res_valid,
	output result_t  res
);

	localparam int LB = LENGTH_BITS;
	localparam int AW = LB + 1;
	localparam int SW = ((LB > 11) ? LB : 11) + 1;
	localparam logic [LB-1:0] POS_MAX = '1;

	logic [LB-1:0] pos_q, nhp_q, tcp_start_q;
	logic [7:0]    proto_q;
	logic [2:0]    phase_q;
	logic [3:0]    doff_q;
	logic [1:0]    early_q;

	logic [LB-1:0] pos_n, nhp_n, tcp_start_n;
	logic [7:0]    proto_n;
	logic [2:0]    phase_n;
	logic [3:0]    doff_n;
	logic [1:0]    early_n;

	logic [SW-1:0] ah_sum;
	logic [AW-1:0] doff_pos;
	logic [AW-1:0] avail;
	logic [7:0]    b;

	assign b        = item.data;
	assign ah_sum   = SW'(nhp_q) + SW'({(9'(b) + 9'd2), 2'b00});
	assign doff_pos = AW'(tcp_start_q) + AW'(TCP_DOFF_BYTE);

	always_comb begin
		pos_n       = pos_q;
		nhp_n       = nhp_q;
		tcp_start_n = tcp_start_q;
		proto_n     = proto_q;
		phase_n     = phase_q;
		doff_n      = doff_q;
		early_n     = early_q;
		if (pos_q == POS_MAX) begin
			early_n = V_TRUNC;
			phase_n = PH_DONE;
		end else begin
			unique case (phase_q)
				PH_WAIT_IP: begin
					if (pos_q == '0) begin
						nhp_n = LB'({b[3:0], 2'b00});
						if (b[3:0] < 4'(IHL_MIN)) begin
							early_n = V_TRUNC;
							phase_n = PH_DONE;
						end
					end else if (pos_q == LB'(IP_PROTO_BYTE)) begin
						proto_n = b;
						phase_n = PH_CHAIN;
					end
				end
				PH_CHAIN: begin
					if (pos_q == nhp_q) begin
						if (proto_q == PROTO_AH) begin
							proto_n = b;
							phase_n = PH_AH_LEN;
						end else if (proto_q == PROTO_TCP) begin
							tcp_start_n = pos_q;
							phase_n     = PH_TCP;
						end else begin
							early_n = V_UNSUPP;
							phase_n = PH_DONE;
						end
					end
				end
				PH_AH_LEN: begin
					// saturate the chain position
					if (ah_sum > SW'(POS_MAX)) begin
						nhp_n = POS_MAX;
					end else begin
						nhp_n = ah_sum[LB-1:0];
					end
					phase_n = PH_CHAIN;
				end
				PH_TCP: begin
					if (AW'(pos_q) == doff_pos) begin
						doff_n = b[7:4];
					end
				end
				default: begin
				end
			endcase
			pos_n = pos_q + LB'(1);
		end
	end

	// bytes from the TCP start up to and including this one
	assign avail = AW'(pos_q) + AW'(1) - AW'(tcp_start_n);

	always_comb begin
		res.verdict = V_TRUNC;
		res.offset  = '0;
		if (phase_n == PH_DONE) begin
			res.verdict = early_n;
		end else if (phase_n == PH_TCP) begin
			if ((avail < AW'(TCP_MIN_LEN)) || (AW'({doff_n, 2'b00}) > avail)) begin
				res.verdict = V_TCP_BAD;
			end else begin
				res.verdict = V_TCP_OK;
				res.offset  = OFFSET_W'(tcp_start_n);
			end
		end
	end

	assign res_valid = step && item.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			nhp_q       <= '0;
			tcp_start_q <= '0;
			proto_q     <= '0;
			phase_q     <= PH_WAIT_IP;
			doff_q      <= '0;
			early_q     <= '0;
		end else if (step) begin
			if (item.last) begin
				pos_q       <= '0;
				nhp_q       <= '0;
				tcp_start_q <= '0;
				proto_q     <= '0;
				phase_q     <= PH_WAIT_IP;
				doff_q      <= '0;
				early_q     <= '0;
			end else begin
				pos_q       <= pos_n;
				nhp_q       <= nhp_n;
				tcp_start_q <= tcp_start_n;
				proto_q     <= proto_n;
				phase_q     <= phase_n;
				doff_q      <= doff_n;
				early_q     <= early_n;
			end
		end
	end

endmodule

/* hdl/ipv4_tcp_header_locator.sv */
// Top level of the IPv4/TCP header locator: input stage, parser, result register.
//
// Takes an IPv4 packet one byte per item on the s_ side, starting at the first
// IP header byte, with s_tlast on the final byte. It reads IHL and protocol,
// walks any chain of AH headers and, on reaching TCP, checks that 20 bytes and
// data-offset*4 bytes fit in the packet. Exactly one result item comes out per
// packet, after its last byte: m_tuser holds the verdict (0 TCP found, 1
// unsupported protocol, 2 truncated header, 3 TCP header invalid) and m_tdata
// the TCP header offset (0 unless the verdict is 0). Throughput is one byte
// per cycle unless the input side stalls; the input register feeds the parse
// state update, a loop on the parse state, and the result register holds the
// verdict. Once accepted, the last byte passes the input register and then its
// verdict the result register before m_tvalid rises. The input side stalls
// only while a finished result waits in the result register and the next
// packet's last byte is already in the input register. Packets longer than
// 2^LENGTH_BITS - 1 bytes are reported as truncated.
module ipv4_tcp_header_locator
	import ipv4tl_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] l4_offset
	output logic [1:0]  m_tuser    // [1:0] verdict
);

	// input stage
	logic     valid_s1;
	in_item_t item_s1;

	// result register
	logic     m_valid_q;
	result_t  res_q;

	logic     out_free;
	logic     advance;
	logic     res_valid;
	result_t  res;

	assign out_free = !m_valid_q || m_tready;
	// a last byte only moves on when the result register can take its verdict
	assign advance  = valid_s1 && (!item_s1.last || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data <= s_tdata;
			item_s1.last <= s_tlast;
		end
	end

	ipv4tl_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q.offset;
	assign m_tuser  = res_q.verdict;

endmodule

/* hdl/ipv4tl_checker.sv */
// Port-level assertions for the IPv4/TCP header locator, bound to the top level.
module ipv4tl_checker
	import ipv4tl_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// input side only stalls behind a waiting result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with free result register");

	// offset is zero unless TCP was found
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != V_TCP_OK) |-> m_tdata == 16'd0)
		else $error("nonzero offset on failure verdict");

	// TCP sits past a full IP header, on a 32-bit boundary
	a_off_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == V_TCP_OK) |-> (m_tdata >= 16'd20) && (m_tdata[1:0] == 2'b00))
		else $error("bad TCP offset");

endmodule

bind ipv4_tcp_header_locator ipv4tl_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
